@@ hw/rtl/tic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer and interrupt controller package
// Word types, operation and register codes, and prescale period lookup.
// ----------------------------------------------------------------------------
package tic_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_READ    = 2'd1,
    OP_WRITE   = 2'd2,
    OP_SERVICE = 2'd3
  } op_t;

  localparam logic [2:0] REG_COUNT   = 3'd0;
  localparam logic [2:0] REG_MODULO  = 3'd1;
  localparam logic [2:0] REG_CONTROL = 3'd2;
  localparam logic [2:0] REG_FLAGS   = 3'd3;
  localparam logic [2:0] REG_ENABLE  = 3'd4;

  localparam int unsigned RUN_BIT_POS   = 2;
  localparam logic [7:0]  TIMER_FLAG    = 8'h04;
  localparam logic [7:0]  UNMAPPED_READ = 8'hFF;
  localparam logic [7:0]  VECTOR_BASE   = 8'h40;
  localparam int unsigned NUM_SOURCES   = 5;

  typedef struct packed {
    op_t        op;
    logic [2:0] reg_sel;
    logic [7:0] write_value;
    logic [7:0] elapsed_cycles;
    logic [4:0] irq_raise;
    logic       master_enable;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       vector_valid;
    logic [7:0] vector_address;
    logic       wake;
  } out_word_t;

  // Prescale period selected by the low two control bits.
  function automatic logic [8:0] prescale_period(input logic [1:0] sel);
    logic [8:0] p;
    case (sel)
      2'd0:    p = 9'd256;
      2'd1:    p = 9'd4;
      2'd2:    p = 9'd16;
      default: p = 9'd64;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/timer_and_interrupt_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer and interrupt controller
// Prescaled timer with modulo reload, interrupt flags and fixed-priority
// vector dispatch, run by a small sequencer around one shared prescale adder.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Word
//   --------+-----------+----------------------+----------------------------
//   in_     | input     | in_valid / in_ready  | tic_pkg::in_word_t
//   out_    | output    | out_valid / out_ready| tic_pkg::out_word_t
//
// Read, write and service words go straight to the result state; the result
// is loaded into the output register once it is free. A tick with the timer
// running adds the elapsed count, then drains whole prescale periods (at most
// 127): the shared 9-bit adder/subtractor removes one period and the counter
// steps once per cycle. A stopped-timer tick goes straight to the result
// state. Reset (rst_n, synchronous, active low) clears all timer and interrupt
// registers and the sequencer. One word is worked on at a time; the output
// register lets the next word be accepted while a result waits to be taken.
module timer_and_interrupt_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tic_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tic_pkg::out_word_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t             state_r, state_nxt;
  logic [8:0]         prescale_r, prescale_nxt;
  logic [8:0]         period_r, period_nxt;
  logic [7:0]         count_r, count_nxt;
  logic [7:0]         modulo_r, modulo_nxt;
  logic [7:0]         control_r, control_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [7:0]         enable_r, enable_nxt;
  tic_pkg::out_word_t res_r, res_nxt;
  tic_pkg::out_word_t out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic               slot_free;
  logic               alu_sub;
  logic [8:0]         alu_b;
  logic [9:0]         alu_res;
  logic               period_due;
  logic [7:0]         count_inc;
  logic [4:0]         pending_ready;
  logic               irq_found;
  logic [2:0]         irq_idx;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The one shared unit: adds elapsed cycles on acceptance, then removes
  // one prescale period per cycle while draining. The tenth bit is the borrow.
  assign alu_sub = (state_r == ST_DRAIN);
  assign alu_b   = alu_sub ? period_r : {1'b0, in_data.elapsed_cycles};
  assign alu_res = alu_sub ? ({1'b0, prescale_r} - {1'b0, alu_b})
                           : ({1'b0, prescale_r} + {1'b0, alu_b});
  assign period_due = alu_sub && !alu_res[9];
  assign count_inc  = count_r + 8'd1;

  // Lowest pending and enabled source wins.
  assign pending_ready = flags_r[4:0] & enable_r[4:0];
  always_comb begin
    irq_found = 1'b0;
    irq_idx   = '0;
    for (int b = tic_pkg::NUM_SOURCES - 1; b >= 0; b--) begin
      if (pending_ready[b]) begin
        irq_found = 1'b1;
        irq_idx   = 3'(b);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    prescale_nxt  = prescale_r;
    period_nxt    = period_r;
    count_nxt     = count_r;
    modulo_nxt    = modulo_r;
    control_nxt   = control_r;
    flags_nxt     = flags_r;
    enable_nxt    = enable_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          state_nxt = ST_RESULT;
          unique case (in_data.op)
            tic_pkg::OP_TICK: begin
              flags_nxt = flags_r | {3'b000, in_data.irq_raise};
              if (control_r[tic_pkg::RUN_BIT_POS]) begin
                prescale_nxt = alu_res[8:0];
                period_nxt   = tic_pkg::prescale_period(control_r[1:0]);
                state_nxt    = ST_DRAIN;
              end
            end
            tic_pkg::OP_READ: begin
              unique case (in_data.reg_sel)
                tic_pkg::REG_COUNT:   res_nxt.read_value = count_r;
                tic_pkg::REG_MODULO:  res_nxt.read_value = modulo_r;
                tic_pkg::REG_CONTROL: res_nxt.read_value = control_r;
                tic_pkg::REG_FLAGS:   res_nxt.read_value = flags_r;
                tic_pkg::REG_ENABLE:  res_nxt.read_value = enable_r;
                default:              res_nxt.read_value = tic_pkg::UNMAPPED_READ;
              endcase
            end
            tic_pkg::OP_WRITE: begin
              unique case (in_data.reg_sel)
                tic_pkg::REG_COUNT:   count_nxt   = in_data.write_value;
                tic_pkg::REG_MODULO:  modulo_nxt  = in_data.write_value;
                tic_pkg::REG_CONTROL: control_nxt = in_data.write_value;
                tic_pkg::REG_FLAGS:   flags_nxt   = in_data.write_value;
                tic_pkg::REG_ENABLE:  enable_nxt  = in_data.write_value;
                default: ;
              endcase
            end
            default: begin
              if (!in_data.master_enable) begin
                res_nxt.wake = |flags_r[4:0];
              end else if (irq_found) begin
                flags_nxt[irq_idx]     = 1'b0;
                res_nxt.vector_valid   = 1'b1;
                res_nxt.wake           = 1'b1;
                res_nxt.vector_address = tic_pkg::VECTOR_BASE + {2'b00, irq_idx, 3'b000};
              end
            end
          endcase
        end
      end

      ST_DRAIN: begin
        if (period_due) begin
          prescale_nxt = alu_res[8:0];
          if (count_inc == 8'd0) begin
            count_nxt = modulo_r;
            flags_nxt = flags_r | tic_pkg::TIMER_FLAG;
          end else begin
            count_nxt = count_inc;
          end
        end else begin
          state_nxt = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (slot_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prescale_r  <= '0;
      count_r     <= '0;
      modulo_r    <= '0;
      control_r   <= '0;
      flags_r     <= '0;
      enable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prescale_r  <= prescale_nxt;
      count_r     <= count_nxt;
      modulo_r    <= modulo_nxt;
      control_r   <= control_nxt;
      flags_r     <= flags_nxt;
      enable_r    <= enable_nxt;
      out_valid_r <= out_valid_nxt;
    end
    period_r   <= period_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Non-tick words, and ticks with the timer stopped, go straight to the result.
  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.op != tic_pkg::OP_TICK || !control_r[tic_pkg::RUN_BIT_POS])
    |=> state_r == ST_RESULT)
    else $error("direct word did not reach the result state");

  // Each drain step removes exactly one period from the prescale count.
  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN && period_due
    |=> prescale_r == $past(prescale_r - period_r))
    else $error("drain step did not remove one period");

  // The drain only ends when less than one period remains.
  a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN && !period_due |-> prescale_r < period_r)
    else $error("drain stopped with a whole period left");

  // A dispatched vector always wakes the CPU and lies in the vector range.
  a_vector_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.vector_valid
    |-> out_data.wake && out_data.vector_address >= 8'h40 &&
        out_data.vector_address <= 8'h60)
    else $error("dispatched vector without wake or out of range");

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result overwritten");

endmodule

@@ sim/timer_and_interrupt_controller_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer and interrupt controller testbench
// Sends directed words and then random tick, read, write and service words
// with random idling on both channels. A scoreboard class keeps its own copy
// of the timer and interrupt state and checks every result word field by field.
// ----------------------------------------------------------------------------
module timer_and_interrupt_controller_test;

  // Register selects with no register behind them read back as all ones.
  localparam logic [2:0] REG_UNMAPPED_FIRST = 3'd5;
  localparam logic [2:0] REG_UNMAPPED_LAST  = 3'd7;
  localparam logic [4:0] SOURCE_MASK        = 5'h1F;
  localparam int unsigned RANDOM_WORDS      = 1500;

  // The scoreboard mirrors the block's state. Every accepted input word is
  // turned into the result word that it must cause, and results are matched
  // in order against those expectations.
  class tic_scoreboard;
    logic [7:0] count_reg;
    logic [7:0] modulo_reg;
    logic [7:0] control_reg;
    logic [8:0] prescale_acc;
    logic [7:0] flag_reg;
    logic [7:0] enable_reg;
    tic_pkg::out_word_t expected_q[$];
    int unsigned error_count;

    function new();
      count_reg    = '0;
      modulo_reg   = '0;
      control_reg  = '0;
      prescale_acc = '0;
      flag_reg     = '0;
      enable_reg   = '0;
      error_count  = 0;
    endfunction

    function void note_input(tic_pkg::in_word_t w);
      tic_pkg::out_word_t res;
      logic [8:0] period;
      logic [4:0] ready_bits;
      res = '0;
      case (w.op)
        tic_pkg::OP_TICK: begin
          flag_reg = flag_reg | {3'b000, w.irq_raise};
          if (control_reg[tic_pkg::RUN_BIT_POS]) begin
            case (control_reg[1:0])
              2'd0:    period = 9'd256;
              2'd1:    period = 9'd4;
              2'd2:    period = 9'd16;
              default: period = 9'd64;
            endcase
            prescale_acc = prescale_acc + {1'b0, w.elapsed_cycles};
            while (prescale_acc >= period) begin
              count_reg = count_reg + 8'd1;
              if (count_reg == 8'd0) begin
                count_reg = modulo_reg;
                flag_reg  = flag_reg | tic_pkg::TIMER_FLAG;
              end
              prescale_acc = prescale_acc - period;
            end
          end
        end
        tic_pkg::OP_READ: begin
          case (w.reg_sel)
            tic_pkg::REG_COUNT:   res.read_value = count_reg;
            tic_pkg::REG_MODULO:  res.read_value = modulo_reg;
            tic_pkg::REG_CONTROL: res.read_value = control_reg;
            tic_pkg::REG_FLAGS:   res.read_value = flag_reg;
            tic_pkg::REG_ENABLE:  res.read_value = enable_reg;
            default:              res.read_value = tic_pkg::UNMAPPED_READ;
          endcase
        end
        tic_pkg::OP_WRITE: begin
          case (w.reg_sel)
            tic_pkg::REG_COUNT:   count_reg   = w.write_value;
            tic_pkg::REG_MODULO:  modulo_reg  = w.write_value;
            tic_pkg::REG_CONTROL: control_reg = w.write_value;
            tic_pkg::REG_FLAGS:   flag_reg    = w.write_value;
            tic_pkg::REG_ENABLE:  enable_reg  = w.write_value;
            default: ;
          endcase
        end
        default: begin
          if (!w.master_enable) begin
            res.wake = |flag_reg[4:0];
          end else begin
            ready_bits = flag_reg[4:0] & enable_reg[4:0] & SOURCE_MASK;
            for (int b = 0; b < tic_pkg::NUM_SOURCES; b++) begin
              if (ready_bits[b] && !res.vector_valid) begin
                flag_reg[b]        = 1'b0;
                res.vector_valid   = 1'b1;
                res.wake           = 1'b1;
                res.vector_address = tic_pkg::VECTOR_BASE + 8'(8 * b);
              end
            end
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                 $time, name, exp_v, act_v);
        error_count++;
      end
    endfunction

    function void check_result(tic_pkg::out_word_t got);
      tic_pkg::out_word_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual 0x%05h",
                 $time, got);
        error_count++;
      end else begin
        exp_w = expected_q.pop_front();
        report_field("read_value", exp_w.read_value, got.read_value);
        report_field("vector_valid", 8'(exp_w.vector_valid), 8'(got.vector_valid));
        report_field("vector_address", exp_w.vector_address, got.vector_address);
        report_field("wake", 8'(exp_w.wake), 8'(got.wake));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tic_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tic_pkg::out_word_t out_data;

  // While set, neither side idles; the random part holds it for a long stretch.
  bit steady_flow;

  tic_scoreboard sb;

  timer_and_interrupt_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous overall limit. The slowest legal run is about 1500 ticks that
  // each drain a hundred or so prescale periods, which stays well below this.
  initial begin
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: ready is redrawn at every falling edge, so stalls land on
  // any phase of the block's work, except during the steady stretch.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready = steady_flow || ($urandom_range(0, 99) >= 25);
    end
  end

  // Every word handed over at a rising edge is checked against the oldest
  // expectation. Sampling at the edge sees the values from before it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  function automatic tic_pkg::in_word_t make_word(tic_pkg::op_t op, logic [2:0] sel,
                                                  logic [7:0] wval, logic [7:0] cyc,
                                                  logic [4:0] irq, logic ime);
    tic_pkg::in_word_t w;
    w.op             = op;
    w.reg_sel        = sel;
    w.write_value    = wval;
    w.elapsed_cycles = cyc;
    w.irq_raise      = irq;
    w.master_enable  = ime;
    return w;
  endfunction

  // Offers one word from a falling edge and holds it until the block takes
  // it. Valid is only lowered for a random gap, never between two words that
  // follow back to back.
  task automatic send_word(tic_pkg::in_word_t w);
    while (!steady_flow && $urandom_range(0, 99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    @(negedge clk);
  endtask

  task automatic send_random_word();
    tic_pkg::in_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      w.op = tic_pkg::OP_TICK;
    else if (pick < 58) w.op = tic_pkg::OP_READ;
    else if (pick < 78) w.op = tic_pkg::OP_WRITE;
    else                w.op = tic_pkg::OP_SERVICE;
    // Mostly real registers, now and then one of the unmapped selects.
    if ($urandom_range(0, 9) == 0)
      w.reg_sel = 3'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST));
    else
      w.reg_sel = 3'($urandom_range(tic_pkg::REG_COUNT, tic_pkg::REG_ENABLE));
    w.write_value = 8'($urandom);
    // Short elapsed counts half the time so that partial periods build up.
    w.elapsed_cycles = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20))
                                                   : 8'($urandom);
    // Requests are held back two times in three, so that service words
    // also meet drained flags.
    w.irq_raise     = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd0;
    w.master_enable = 1'($urandom);
    send_word(w);
  endtask

  initial begin
    sb          = new();
    steady_flow = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. After reset everything reads zero and the timer is
    // stopped; unmapped selects read all ones and ignore writes.
    send_word(make_word(tic_pkg::OP_READ, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_READ, REG_UNMAPPED_LAST, 8'h00, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_WRITE, REG_UNMAPPED_FIRST, 8'hAA, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_READ, REG_UNMAPPED_FIRST, 8'h00, 8'h00, 5'h00, 1'b0));
    // A stopped timer still takes requests but does not count.
    send_word(make_word(tic_pkg::OP_TICK, tic_pkg::REG_COUNT, 8'h00, 8'hFF, 5'h1F, 1'b0));
    send_word(make_word(tic_pkg::OP_READ, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b0));
    // Shortest period with the largest elapsed count wraps the counter and
    // reloads it from the modulo register.
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_MODULO, 8'hF0, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_COUNT, 8'hFE, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_CONTROL, 8'h05, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_TICK, tic_pkg::REG_COUNT, 8'h00, 8'hFF, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_READ, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b0));
    // A period change keeps the leftover prescale count.
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_CONTROL, 8'h06, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_TICK, tic_pkg::REG_COUNT, 8'h00, 8'h0D, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_CONTROL, 8'h04, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_TICK, tic_pkg::REG_COUNT, 8'h00, 8'hFF, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_TICK, tic_pkg::REG_COUNT, 8'h00, 8'h01, 5'h00, 1'b0));
    // Control keeps all eight bits; enable bits above the sources dispatch
    // nothing, but a clear master enable still reports wake.
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_CONTROL, 8'hFF, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_READ, tic_pkg::REG_CONTROL, 8'h00, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_ENABLE, 8'hE0, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_SERVICE, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b1));
    send_word(make_word(tic_pkg::OP_SERVICE, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b0));
    // Highest priority first, then the lowest-priority source alone, then
    // a service with nothing left pending.
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_ENABLE, 8'hFF, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_SERVICE, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b1));
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_FLAGS, 8'h10, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_SERVICE, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b1));
    send_word(make_word(tic_pkg::OP_SERVICE, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b1));
    // Flag bits above the sources are stored but never wake the CPU.
    send_word(make_word(tic_pkg::OP_WRITE, tic_pkg::REG_FLAGS, 8'hE0, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_SERVICE, tic_pkg::REG_COUNT, 8'h00, 8'h00, 5'h00, 1'b0));
    send_word(make_word(tic_pkg::OP_READ, tic_pkg::REG_FLAGS, 8'h00, 8'h00, 5'h00, 1'b0));

    // Random part, with a stretch of back-to-back traffic and one pause in
    // which the sender holds off until every result has been taken.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady_flow = (i >= 400) && (i < 700);
      if (i == 1000) begin
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
      send_random_word();
    end
    steady_flow = 1'b0;
    in_valid    = 1'b0;

    // Drain, then leave room for any stray result. A running tick holds the
    // block until all of its whole prescale periods are drained.
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ timer_and_interrupt_controller.f @@
hw/rtl/tic_pkg.sv
hw/rtl/timer_and_interrupt_controller.sv
sim/timer_and_interrupt_controller_test.sv
